/* rtl/wsr_pkg.sv */
// ----------------------------------------------------------------------------
// wsr_pkg: shared types and constants of the windowed segment receiver
// beat layouts of the request and response channels, result kinds, sequencer
// states and default sizes
// ----------------------------------------------------------------------------
package wsr_pkg;

   // sequence number width, fixed by the beat layout
   localparam int SEQ_BITS = 16;

   // default receive window depth
   localparam int WINDOW_SIZE_DEF = 32;

   // field widths
   localparam int PATH_W = 2;
   localparam int PAYLOAD_W = 32;
   localparam int LENGTH_W = 11;
   localparam int KIND_W = 2;

   // stored slot word: payload and length side by side
   localparam int SLOT_W = PAYLOAD_W + LENGTH_W;

   // request command codes
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_FIN = 1'b1;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_ACK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIN = 2'd2;

   typedef struct packed {
      logic command;
      logic [PATH_W-1:0] path;
      logic [SEQ_BITS-1:0] seq_number;
      logic [PAYLOAD_W-1:0] payload;
      logic [LENGTH_W-1:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [PATH_W-1:0] reply_path;
      logic [SEQ_BITS-1:0] ack_number;
      logic [PAYLOAD_W-1:0] out_payload;
      logic [LENGTH_W-1:0] out_length;
      logic last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_FLUSH
   } state_type;

endpackage

/* rtl/wsr_ram.sv */
// ----------------------------------------------------------------------------
// wsr_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module wsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/windowed_segment_receiver.sv */
// ----------------------------------------------------------------------------
// windowed_segment_receiver: selective repeat receive window
// stores in-window segments, acks them, flushes the window in order when it
// is full and a segment beyond it arrives, and flushes the received prefix
// on fin
// ----------------------------------------------------------------------------
// Usage
//   A segment beat is taken at a rising edge with start high and busy low.
//   Each response beat sits on rsp_data for one cycle with rsp_valid high;
//   rsp_data.last marks the final beat caused by a segment. The receiver
//   cannot stall, so beats are never held.
//   Timing: a segment is accepted, decided in the next cycle, and its ack
//   appears in the cycle after the decide. Busy stays high while a segment
//   is decided, so a new segment is taken only once the block is idle again.
//   A flush reads the payload ram one slot per cycle; the fin ack is
//   followed by its flush beats without a gap. The single read port of the
//   slot ram sets the one beat per cycle. Segments that cause no response
//   (beyond the window while it is not full, or anything after fin) still
//   pass through the decide state and keep busy high there.
//   Reset sets the window base to 1, clears the received bitmap and the fin
//   flag; the slot ram is not cleared, only slots marked received are read.
// ----------------------------------------------------------------------------
module windowed_segment_receiver
   import wsr_pkg::*;
#(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IdxW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam logic [IdxW-1:0] IdxLast = IdxW'(WINDOW_SIZE - 1);

   // sequencer and window state
   state_type state_ff, state_in;
   logic [SEQ_BITS-1:0] base_ff, base_in;
   logic [WINDOW_SIZE-1:0] map_ff, map_in;
   logic done_ff, done_in;

   // captured segment and flush control
   req_type req_ff;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic fin_mode_ff, fin_mode_in;

   // response register
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // slot ram port
   logic ram_wr_en;
   logic [IdxW-1:0] ram_wr_addr;
   logic [SLOT_W-1:0] ram_wr_data;
   logic [IdxW-1:0] ram_rd_addr;
   logic [SLOT_W-1:0] ram_rd_data;

   // window decode of the captured segment
   logic [SEQ_BITS:0] win_end;
   logic beyond;
   logic full;
   logic [SEQ_BITS-1:0] offset;
   logic in_win;
   logic [IdxW-1:0] off_idx;
   logic [IdxW-1:0] idx_nxt;
   logic next_set;
   logic flush_last;

   assign win_end = {1'b0, base_ff} + (SEQ_BITS + 1)'(WINDOW_SIZE - 1);
   assign beyond = {1'b0, req_ff.seq_number} > win_end;
   assign full = &map_ff;
   assign offset = req_ff.seq_number - base_ff;
   assign in_win = (req_ff.seq_number >= base_ff) && (offset < SEQ_BITS'(WINDOW_SIZE));
   assign off_idx = offset[IdxW-1:0];

   // end of flush: last slot, or first empty slot ahead in fin mode
   assign idx_nxt = idx_ff + 1'b1;
   assign next_set = (idx_ff == IdxLast) ? 1'b0 : map_ff[idx_nxt];
   assign flush_last = (idx_ff == IdxLast) || (fin_mode_ff && !next_set);

   assign busy = (state_ff != ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            if (!done_ff) begin
               if (req_ff.command == CMD_FIN) begin
                  if (map_ff[0]) begin
                     state_in = ST_FLUSH;
                  end
               end else if (beyond && full) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (flush_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and response
   always_comb begin
      base_in = base_ff;
      map_in = map_ff;
      done_in = done_ff;
      idx_in = idx_ff;
      fin_mode_in = fin_mode_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in = '0;
      ram_wr_en = 1'b0;
      ram_wr_addr = off_idx;
      ram_wr_data = {req_ff.payload, req_ff.payload_length};
      ram_rd_addr = '0;
      case (state_ff)
         ST_IDLE: begin
         end
         ST_DECIDE: begin
            idx_in = '0;
            if (!done_ff) begin
               if (req_ff.command == CMD_FIN) begin
                  // fin ack, then the received prefix
                  fin_mode_in = 1'b1;
                  done_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_data_in.kind = KIND_FIN;
                  rsp_data_in.reply_path = req_ff.path;
                  rsp_data_in.ack_number = req_ff.seq_number;
                  rsp_data_in.last = !map_ff[0];
               end else if (beyond) begin
                  // full window moves on, otherwise silently dropped
                  fin_mode_in = 1'b0;
                  if (full) begin
                     map_in = '0;
                     base_in = base_ff + SEQ_BITS'(WINDOW_SIZE);
                  end
               end else begin
                  // ack, store if new in window
                  if (in_win && !map_ff[off_idx]) begin
                     map_in[off_idx] = 1'b1;
                     ram_wr_en = 1'b1;
                  end
                  rsp_valid_in = 1'b1;
                  rsp_data_in.kind = KIND_ACK;
                  rsp_data_in.reply_path = req_ff.path;
                  rsp_data_in.ack_number = req_ff.seq_number;
                  rsp_data_in.last = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            // emit the slot read last cycle, fetch the next one
            rsp_valid_in = 1'b1;
            rsp_data_in.kind = KIND_FLUSH;
            rsp_data_in.out_payload = ram_rd_data[SLOT_W-1:LENGTH_W];
            rsp_data_in.out_length = ram_rd_data[LENGTH_W-1:0];
            rsp_data_in.last = flush_last;
            idx_in = idx_nxt;
            ram_rd_addr = idx_nxt;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_ff <= SEQ_BITS'(1);
         map_ff <= '0;
         done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         map_ff <= map_in;
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      idx_ff <= idx_in;
      fin_mode_ff <= fin_mode_in;
      rsp_data_ff <= rsp_data_in;
   end

   wsr_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(WINDOW_SIZE)
   ) u_slot_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // an accepted segment is always decided next
   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_DECIDE))
      else $error("accepted segment not decided");

   // a response beat only follows a decide or flush cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_DECIDE || $past(state_ff) == ST_FLUSH))
      else $error("response beat without a source");

   // the session stays closed after fin
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("session reopened after fin");

   // the flush pointer stays inside the window
   a_flush_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (idx_ff <= IdxLast))
      else $error("flush index out of window");

   // every flush run ends with a beat marked last
   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && state_in == ST_IDLE) |=> (rsp_valid_ff && rsp_data_ff.last))
      else $error("flush ended without last beat");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the windowed segment receiver
// a table of directed segments, then rounds of random window fills mixed with
// duplicates, stale and out-of-window segments, then a closing fin. every
// accepted segment runs through an in-bench window model whose beats, or a
// typed row's beat, are queued and compared field by field to the rsp channel
// ----------------------------------------------------------------------------
module tb_top
   import wsr_pkg::*;
();

   localparam int WIN = WINDOW_SIZE_DEF;
   localparam int RANDOM_SEGMENTS = 240;

   // one directed step: segment plus an optional hand-written expectation
   // typed_count: -1 use the window model, 0 no beat, 1 the single typed beat
   typedef struct {
      req_type seg;
      int typed_count;
      rsp_type typed_rsp;
   } step_row_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;

   // window model state
   logic [SEQ_BITS-1:0] win_base;
   logic [WIN-1:0] rcv_map;
   logic [PAYLOAD_W-1:0] slot_pay [WIN];
   logic [LENGTH_W-1:0] slot_len [WIN];
   bit fin_seen;

   // beats still owed by the block, oldest first
   rsp_type owed_beats[$];

   // sideband from the sender to the monitor for typed table rows
   int typed_count;
   rsp_type typed_rsp;

   int error_count;
   int burst_left;

   step_row_type dir_table[$];
   req_type seg;
   rsp_type none_rsp;
   int sent_random;
   int pick;
   int off;
   int k;
   int prefix_len;
   int drain_cycles;
   bit first_flush;
   bit flush_sent;

   windowed_segment_receiver dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type make_rsp(input logic [KIND_W-1:0] kind,
                                        input logic [PATH_W-1:0] rpath,
                                        input logic [SEQ_BITS-1:0] ackn,
                                        input logic [PAYLOAD_W-1:0] pay,
                                        input logic [LENGTH_W-1:0] len);
      rsp_type r;
      r.kind = kind;
      r.reply_path = rpath;
      r.ack_number = ackn;
      r.out_payload = pay;
      r.out_length = len;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic step_row_type mk_row(input logic [PATH_W-1:0] path,
                                           input logic [SEQ_BITS-1:0] seqn,
                                           input logic [PAYLOAD_W-1:0] pay,
                                           input logic [LENGTH_W-1:0] len,
                                           input int cnt);
      step_row_type s;
      s.seg.command = CMD_DATA;
      s.seg.path = path;
      s.seg.seq_number = seqn;
      s.seg.payload = pay;
      s.seg.payload_length = len;
      s.typed_count = cnt;
      s.typed_rsp = make_rsp(KIND_ACK, path, seqn, '0, '0);
      s.typed_rsp.last = 1'b1;
      return s;
   endfunction

   function automatic req_type rand_seg(input logic [SEQ_BITS-1:0] seqn);
      req_type s;
      s.command = CMD_DATA;
      s.path = PATH_W'($urandom_range(0, 3));
      s.seq_number = seqn;
      s.payload = $urandom;
      s.payload_length = ($urandom_range(0, 9) == 0) ? LENGTH_W'($urandom_range(0, 2047))
                                                      : LENGTH_W'($urandom_range(0, 1024));
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // window model: advance the state by one segment, queue its beats if asked
   task automatic window_step(input req_type s, input bit record);
      logic [SEQ_BITS:0] win_end;
      rsp_type beats[$];
      int i;
      int slot;
      if (!fin_seen) begin
         win_end = {1'b0, win_base} + (SEQ_BITS+1)'(WIN - 1);
         if (s.command == CMD_FIN) begin
            // fin ack, then the contiguous received prefix
            beats.push_back(make_rsp(KIND_FIN, s.path, s.seq_number, '0, '0));
            for (i = 0; i < WIN && rcv_map[i]; i++)
               beats.push_back(make_rsp(KIND_FLUSH, '0, '0, slot_pay[i], slot_len[i]));
            fin_seen = 1'b1;
         end else if ({1'b0, s.seq_number} > win_end) begin
            // beyond the window: flush only when every slot is filled
            if (&rcv_map) begin
               for (i = 0; i < WIN; i++)
                  beats.push_back(make_rsp(KIND_FLUSH, '0, '0, slot_pay[i], slot_len[i]));
               rcv_map = '0;
               win_base = win_base + SEQ_BITS'(WIN);
            end
         end else begin
            // in window or below base: always acked, stored only when new
            if (s.seq_number >= win_base) begin
               slot = int'(s.seq_number - win_base);
               if (!rcv_map[slot]) begin
                  rcv_map[slot] = 1'b1;
                  slot_pay[slot] = s.payload;
                  slot_len[slot] = s.payload_length;
               end
            end
            beats.push_back(make_rsp(KIND_ACK, s.path, s.seq_number, '0, '0));
         end
         if (beats.size() > 0)
            beats[beats.size()-1].last = 1'b1;
         if (record)
            foreach (beats[j])
               owed_beats.push_back(beats[j]);
      end
   endtask

   // sender: bursts with random gaps, holds the beat until it is taken
   task automatic send_segment(input req_type s, input int cnt, input rsp_type trsp);
      if (burst_left == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 10);
      end
      burst_left--;
      req_data = s;
      typed_count = cnt;
      typed_rsp = trsp;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // monitor: check response beats, feed accepted segments to the model
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (owed_beats.size() == 0) begin
               report_mismatch("unexpected beat kind", 32'(rsp_data.kind), 32'hffff_ffff);
            end else begin
               want = owed_beats.pop_front();
               if (rsp_data.kind !== want.kind)
                  report_mismatch("kind", 32'(rsp_data.kind), 32'(want.kind));
               if (rsp_data.reply_path !== want.reply_path)
                  report_mismatch("reply_path", 32'(rsp_data.reply_path), 32'(want.reply_path));
               if (rsp_data.ack_number !== want.ack_number)
                  report_mismatch("ack_number", 32'(rsp_data.ack_number), 32'(want.ack_number));
               if (rsp_data.out_payload !== want.out_payload)
                  report_mismatch("out_payload", rsp_data.out_payload, want.out_payload);
               if (rsp_data.out_length !== want.out_length)
                  report_mismatch("out_length", 32'(rsp_data.out_length), 32'(want.out_length));
               if (rsp_data.last !== want.last)
                  report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
            end
         end
         if (start && !busy) begin
            if (typed_count < 0) begin
               window_step(req_data, 1'b1);
            end else begin
               window_step(req_data, 1'b0);
               if (typed_count == 1)
                  owed_beats.push_back(typed_rsp);
            end
         end
      end
   end

   // run limit
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      typed_count = -1;
      typed_rsp = '0;
      none_rsp = '0;
      error_count = 0;
      burst_left = 0;
      win_base = SEQ_BITS'(1);
      rcv_map = '0;
      fin_seen = 1'b0;
      first_flush = 1'b1;
      foreach (slot_pay[i]) begin
         slot_pay[i] = '0;
         slot_len[i] = '0;
      end

      // directed table, window base is 1 after reset
      dir_table.push_back(mk_row(2'd0, 16'd1, 32'h0000_0000, 11'd0, 1));       // first slot
      dir_table.push_back(mk_row(2'd3, 16'd2, 32'hffff_ffff, 11'd1024, 1));    // path three
      dir_table.push_back(mk_row(2'd1, 16'd32, 32'ha5a5_a5a5, 11'd2047, 1));   // window end
      dir_table.push_back(mk_row(2'd2, 16'd33, 32'h1234_5678, 11'd5, 0));      // just beyond
      dir_table.push_back(mk_row(2'd2, 16'hffff, 32'hdead_beef, 11'd7, 0));    // far beyond
      dir_table.push_back(mk_row(2'd1, 16'd0, 32'h0bad_f00d, 11'd9, 1));       // below base
      dir_table.push_back(mk_row(2'd0, 16'd1, 32'hcafe_0001, 11'd3, 1));       // duplicate
      dir_table.push_back(mk_row(2'd2, 16'd16, 32'h5a5a_5a5a, 11'd1, 1));
      dir_table.push_back(mk_row(2'd3, 16'd3, 32'h0000_0001, 11'd1023, -1));
      dir_table.push_back(mk_row(2'd1, 16'd4, 32'h8000_0000, 11'd512, -1));
      dir_table.push_back(mk_row(2'd0, 16'd5, 32'h7fff_ffff, 11'd256, -1));
      dir_table.push_back(mk_row(2'd2, 16'd31, 32'h0f0f_0f0f, 11'd0, -1));
      dir_table.push_back(mk_row(2'd3, 16'd32, 32'hf0f0_f0f0, 11'd100, -1));   // duplicate end

      repeat (8) @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[i])
         send_segment(dir_table[i].seg, dir_table[i].typed_count, dir_table[i].typed_rsp);

      // random rounds: fill the window, mix in noise, trigger the flush
      sent_random = 0;
      while (sent_random < RANDOM_SEGMENTS) begin
         pick = $urandom_range(0, 99);
         flush_sent = 1'b0;
         if (&rcv_map && pick < 85) begin
            seg = rand_seg(win_base + SEQ_BITS'(WIN) + SEQ_BITS'($urandom_range(0, 40)));
            flush_sent = 1'b1;
         end else if (!(&rcv_map) && pick < 75) begin
            off = $urandom_range(0, WIN - 1);
            while (rcv_map[off]) off = (off + 1) % WIN;
            seg = rand_seg(win_base + SEQ_BITS'(off));
         end else if (pick < 82) begin
            seg = rand_seg(win_base + SEQ_BITS'($urandom_range(0, WIN - 1)));
         end else if (pick < 90) begin
            seg = rand_seg(SEQ_BITS'($urandom_range(0, int'(win_base) - 1)));
         end else begin
            seg = rand_seg(SEQ_BITS'($urandom_range(0, 65535)));
         end
         send_segment(seg, -1, none_rsp);
         sent_random++;
         // on the first flush, and at random after it, hold the sender off until the flush has fully drained
         if (flush_sent && (first_flush || $urandom_range(0, 1) == 0)) begin
            first_flush = 1'b0;
            start = 1'b0;
            do @(negedge clock); while (owed_beats.size() != 0);
         end
      end

      // closing: build a received prefix of random length, then fin
      prefix_len = ($urandom_range(0, 2) == 0) ? WIN : $urandom_range(0, WIN - 1);
      for (k = 0; k < prefix_len; k++)
         if (!rcv_map[k])
            send_segment(rand_seg(win_base + SEQ_BITS'(k)), -1, none_rsp);
      seg = rand_seg(SEQ_BITS'($urandom_range(0, 65535)));
      seg.command = CMD_FIN;
      send_segment(seg, -1, none_rsp);

      // after fin everything is ignored
      for (k = 0; k < 4; k++) begin
         seg = rand_seg(win_base + SEQ_BITS'(k));
         seg.command = (k % 2 == 0) ? CMD_FIN : CMD_DATA;
         send_segment(seg, -1, none_rsp);
      end
      start = 1'b0;

      // drain
      drain_cycles = 0;
      while (owed_beats.size() != 0 && drain_cycles < 5000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (40) @(negedge clock);
      if (owed_beats.size() != 0)
         report_mismatch("beats never delivered", 32'(owed_beats.size()), 32'd0);

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
